// ===== hw/rtl/b2da_pkg.sv =====
// shared types and constants for the binary to decimal ascii converter
// no dependencies; used by b2da_dabble and binary_to_decimal_ascii
package b2da_pkg;

   // decimal digit storage, enough for any value up to 64 bits
   localparam int DIGIT_SLOTS = 20;
   localparam int DIGIT_W     = 4;
   localparam int BCD_BITS    = DIGIT_SLOTS * DIGIT_W;
   localparam int COUNT_W     = $clog2(DIGIT_SLOTS + 1);

   // field widths
   localparam int VALUE_W   = 64;
   localparam int CHAR_W    = 6;
   localparam int BUF_W     = 8;

   // parameter defaults
   localparam int VALUE_BITS_DEF = 64;
   localparam int MAX_DIGITS_DEF = 20;

   // register reset and character constants
   localparam logic [BUF_W-1:0]  BUF_SIZE_RESET = 8'd21;
   localparam logic [CHAR_W-1:0] ASCII_ZERO     = 6'd48;
   localparam logic [CHAR_W-1:0] ASCII_NINE     = 6'd57;
   localparam logic [CHAR_W-1:0] CHAR_NONE      = 6'd0;

   // status from the conversion unit to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } dab_status_type;

endpackage

// ===== hw/rtl/binary_to_decimal_ascii.sv =====
// binary to decimal ascii converter, top level: handshakes, buffer size register, digit output
// depends on b2da_pkg and b2da_dabble
//
// channel   direction  transfer fields
// req_*     in         tdata[63:0] value
// rsp_*     out        tdata[5:0] digit_char (zero padded to 8), tlast last, tuser overflow
// csr_*     in         data[7:0] buffer_size
//
// an item runs the serial double dabble over all VALUE_BITS bits, then sends one result per digit
// (or one overflow result instead of the digits)
// the dabble loop takes one bit per cycle; one value is converted at a time
// reset is synchronous; buffer_size returns to 21
// a stalled rsp_tready holds the current result; req_tready is high only while idle
module binary_to_decimal_ascii #(
   parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF,
   parameter int MAX_DIGITS = b2da_pkg::MAX_DIGITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // value
   input  logic [63:0] req_tdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   // digit_char[5:0], zero [7:6]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast,
   // overflow
   output logic        rsp_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // buffer_size
   input  logic [7:0]  csr_data,
   input  logic        csr_valid,
   output logic        csr_ready
);

   localparam int CW = b2da_pkg::COUNT_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_EMIT
   } state_type;

   state_type                        state_ff, state_in;
   logic [b2da_pkg::BCD_BITS-1:0]    digits_ff, digits_in;
   logic [CW-1:0]                    ndig_ff, ndig_in;
   logic [CW-1:0]                    left_ff, left_in;
   logic                             ovf_ff, ovf_in;
   logic [b2da_pkg::BUF_W-1:0]       buf_size_ff, buf_size_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [b2da_pkg::CHAR_W-1:0]      rsp_char_ff, rsp_char_in;
   logic                             rsp_last_ff, rsp_last_in;
   logic                             rsp_ovf_ff, rsp_ovf_in;

   b2da_pkg::dab_status_type         dab_status;
   logic [b2da_pkg::BCD_BITS-1:0]    dab_bcd;
   logic [CW-1:0]                    dab_count;
   logic                             req_xfer;
   logic [b2da_pkg::DIGIT_W-1:0]     top_digit;

   assign req_xfer = req_tvalid && req_tready;

   // serial conversion unit
   b2da_dabble #(
      .VALUE_BITS (VALUE_BITS)
   ) u_dabble (
      .clock  (clock),
      .reset  (reset),
      .start  (req_xfer),
      .value  (req_tdata[VALUE_BITS-1:0]),
      .status (dab_status),
      .bcd    (dab_bcd),
      .count  (dab_count)
   );

   // most significant remaining digit sits at a fixed place for the whole item
   always_comb begin
      top_digit = '0;
      for (int i = 0; i < b2da_pkg::DIGIT_SLOTS; i++) begin
         if (CW'(i) == ndig_ff - CW'(1)) begin
            top_digit = digits_ff[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W];
         end
      end
   end

   // sequencer and output register
   always_comb begin
      state_in     = state_ff;
      digits_in    = digits_ff;
      ndig_in      = ndig_ff;
      left_in      = left_ff;
      ovf_in       = ovf_ff;
      buf_size_in  = buf_size_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_ovf_in   = rsp_ovf_ff;

      // result taken by the sink
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      // buffer size write
      if (csr_valid) begin
         buf_size_in = csr_data;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            if (dab_status.done) begin
               digits_in = dab_bcd;
               ndig_in   = dab_count;
               left_in   = dab_count;
               ovf_in    = (dab_count > CW'(MAX_DIGITS)) ||
                           ({{(b2da_pkg::BUF_W-CW){1'b0}}, dab_count} >= buf_size_ff);
               state_in  = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (ovf_ff) begin
                  rsp_char_in = b2da_pkg::CHAR_NONE;
                  rsp_last_in = 1'b1;
                  rsp_ovf_in  = 1'b1;
                  state_in    = ST_IDLE;
               end else begin
                  rsp_char_in = b2da_pkg::ASCII_ZERO +
                                {{(b2da_pkg::CHAR_W-b2da_pkg::DIGIT_W){1'b0}}, top_digit};
                  rsp_last_in = (left_ff == CW'(1));
                  rsp_ovf_in  = 1'b0;
                  digits_in   = {digits_ff[b2da_pkg::BCD_BITS-b2da_pkg::DIGIT_W-1:0],
                                 {b2da_pkg::DIGIT_W{1'b0}}};
                  left_in     = left_ff - CW'(1);
                  if (left_ff == CW'(1)) begin
                     state_in = ST_IDLE;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      digits_ff   <= digits_in;
      ndig_ff     <= ndig_in;
      left_ff     <= left_in;
      ovf_ff      <= ovf_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
      rsp_ovf_ff  <= rsp_ovf_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         buf_size_ff  <= b2da_pkg::BUF_SIZE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         buf_size_ff  <= buf_size_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_char_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_ovf_ff;
   assign csr_ready  = 1'b1;

   // an overflow result is a single final result with no character
   a_ovf_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ovf_ff |-> rsp_last_ff && rsp_char_ff == b2da_pkg::CHAR_NONE)
      else $error("overflow result malformed");

   // a digit result always carries a decimal ascii character
   a_digit_char: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ovf_ff |->
         rsp_char_ff >= b2da_pkg::ASCII_ZERO && rsp_char_ff <= b2da_pkg::ASCII_NINE)
      else $error("digit result outside 0 to 9");

   // an accepted value starts the conversion unit at once
   a_start_convert: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> state_ff == ST_CONVERT && dab_status.busy)
      else $error("conversion did not start");

   // the conversion unit only finishes while the sequencer waits for it
   a_done_in_convert: assert property (@(posedge clock) disable iff (reset)
      dab_status.done |-> state_ff == ST_CONVERT)
      else $error("conversion finished outside the convert phase");

   // digits still to send stay within the digit count
   a_left_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT && !ovf_ff |-> left_ff != '0 && left_ff <= ndig_ff)
      else $error("remaining digit count out of range");

endmodule

// ===== hw/rtl/b2da_dabble.sv =====
// bit-serial double dabble unit: one binary bit enters the bcd register per cycle
// depends on b2da_pkg
module b2da_dabble #(
   parameter int VALUE_BITS = b2da_pkg::VALUE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [VALUE_BITS-1:0]              value,
   output b2da_pkg::dab_status_type           status,
   output logic [b2da_pkg::BCD_BITS-1:0]      bcd,
   output logic [b2da_pkg::COUNT_W-1:0]       count
);

   localparam int BITS_W = $clog2(VALUE_BITS + 1);

   logic [VALUE_BITS-1:0]            bin_ff, bin_in;
   logic [b2da_pkg::BCD_BITS-1:0]    bcd_ff, bcd_in;
   logic [b2da_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [BITS_W-1:0]                bits_ff, bits_in;
   logic                             busy_ff, busy_in;
   logic                             done_ff, done_in;

   logic [b2da_pkg::BCD_BITS-1:0]    adjusted;
   logic [b2da_pkg::BCD_BITS-1:0]    shifted;
   logic                             grow;

   // add three to every digit of five or more, then shift in the next bit
   always_comb begin
      adjusted = bcd_ff;
      for (int i = 0; i < b2da_pkg::DIGIT_SLOTS; i++) begin
         if (bcd_ff[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] >= 4'd5) begin
            adjusted[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] =
               bcd_ff[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] + 4'd3;
         end
      end
      shifted = {adjusted[b2da_pkg::BCD_BITS-2:0], bin_ff[VALUE_BITS-1]};
   end

   // the digit count grows by at most one per doubling
   always_comb begin
      grow = 1'b0;
      for (int i = 0; i < b2da_pkg::DIGIT_SLOTS; i++) begin
         if (b2da_pkg::COUNT_W'(i) == count_ff &&
             shifted[i*b2da_pkg::DIGIT_W +: b2da_pkg::DIGIT_W] != '0) begin
            grow = 1'b1;
         end
      end
   end

   // next state of the conversion
   always_comb begin
      bin_in   = bin_ff;
      bcd_in   = bcd_ff;
      count_in = count_ff;
      bits_in  = bits_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (start) begin
         bin_in   = value;
         bcd_in   = '0;
         count_in = b2da_pkg::COUNT_W'(1);
         bits_in  = BITS_W'(VALUE_BITS);
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         bin_in   = {bin_ff[VALUE_BITS-2:0], 1'b0};
         bcd_in   = shifted;
         count_in = count_ff + b2da_pkg::COUNT_W'(grow);
         bits_in  = bits_ff - BITS_W'(1);
         if (bits_ff == BITS_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      bin_ff   <= bin_in;
      bcd_ff   <= bcd_in;
      count_ff <= count_in;
      bits_ff  <= bits_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign bcd         = bcd_ff;
   assign count       = count_ff;

   // completion follows the last shift and ends the busy phase
   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("conversion finished without a running conversion");

   // the digit count never exceeds the bcd register
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> count_ff != '0 && count_ff <= b2da_pkg::COUNT_W'(b2da_pkg::DIGIT_SLOTS))
      else $error("digit count out of range");

   // the least significant stored digit is decimal when a conversion finishes
   a_digits_decimal: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> bcd_ff[b2da_pkg::DIGIT_W-1:0] <= 4'd9)
      else $error("least significant digit is not decimal");

endmodule
